// ===== sv/ste_pkg.sv =====
// shared constants and types for the sorted table engine
package ste_pkg;

  localparam int unsigned DEF_CAPACITY = 256;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned INDEX_W      = 8;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned CMD_W        = 3;

  localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

  localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET          = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND         = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE_VALUE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic               ins;
    logic               del_idx;
    logic               del_val;
    logic [VALUE_W-1:0] value;
  } ste_ctrl_t;

endpackage

// ===== sv/ste_cell.sv =====
// one table cell: holds an entry, latches compare flags, shifts with its neighbors
module ste_cell import ste_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic               clk,
  input  logic               load,
  input  logic [VALUE_W-1:0] cmp_value,
  input  logic [INDEX_W-1:0] cmp_index,
  input  logic [CW-1:0]      count,
  input  ste_ctrl_t          ctrl,
  input  logic [VALUE_W-1:0] prev_value,
  input  logic               prev_le,
  input  logic               prev_eq,
  input  logic [VALUE_W-1:0] next_value,
  output logic [VALUE_W-1:0] value,
  output logic               le,
  output logic               eq,
  output logic               ins_mark,
  output logic               find_mark,
  output logic               hit
);

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               le_r, le_nxt;
  logic               eq_r, eq_nxt;
  logic               ge_r, ge_nxt;
  logic               idxge_r, idxge_nxt;
  logic               hit_r, hit_nxt;
  logic               valid;

  assign valid = 32'(IDX) < 32'(count);

  always_comb begin
    le_nxt    = valid && (value_r <= cmp_value);
    eq_nxt    = valid && (value_r == cmp_value);
    ge_nxt    = valid && (value_r >= cmp_value);
    idxge_nxt = 32'(IDX) >= 32'(cmp_index);
    hit_nxt   = 32'(IDX) == 32'(cmp_index);
  end

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins && !le_r) begin
      value_nxt = prev_le ? ctrl.value : prev_value;
    end else if (ctrl.del_idx && idxge_r) begin
      value_nxt = next_value;
    end else if (ctrl.del_val && ge_r) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (load) begin
      le_r    <= le_nxt;
      eq_r    <= eq_nxt;
      ge_r    <= ge_nxt;
      idxge_r <= idxge_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign value     = value_r;
  assign le        = le_r;
  assign eq        = eq_r;
  assign ins_mark  = !le_r && prev_le;
  assign find_mark = eq_r && !prev_eq;
  assign hit       = hit_r;

endmodule

// ===== sv/ste_encode.sv =====
// resolves the one-hot cell marks into positions, a found flag and the word read by get
module ste_encode import ste_pkg::*; #(
  parameter int unsigned N  = 256,
  parameter int unsigned IW = 8
) (
  input  logic [N-1:0]       ins_mark,
  input  logic [N-1:0]       find_mark,
  input  logic [N-1:0]       hit,
  input  logic [VALUE_W-1:0] values [N],
  output logic [IW-1:0]      ins_pos,
  output logic [IW-1:0]      find_pos,
  output logic               found,
  output logic [VALUE_W-1:0] get_value
);

  always_comb begin
    ins_pos   = '0;
    find_pos  = '0;
    get_value = '0;
    for (int i = 0; i < N; i++) begin
      ins_pos   = ins_pos | (ins_mark[i] ? IW'(i) : '0);
      find_pos  = find_pos | (find_mark[i] ? IW'(i) : '0);
      get_value = get_value | (hit[i] ? values[i] : '0);
    end
    found = |find_mark;
  end

endmodule

// ===== sv/sorted_table_engine.sv =====
// top level of the sorted table engine: cell row, encoder, control and result register
//
// The table is a row of CAPACITY cells kept in ascending unsigned order. Each command
// passes through ST_IDLE and ST_EXEC: when the word is accepted each cell compares its
// entry with the broadcast value and index and latches its flags; in ST_EXEC the
// encoder turns the flags into a position, and for insert and delete the cells from
// there on shift by one place at once (up for insert, down for delete) while the result
// is written to the output register. A new word is taken only in ST_IDLE; the output
// register lets the next command be accepted while a result still waits, and a command
// stays in ST_EXEC only while the previous result has not been taken. There is no
// clearing pass after reset: entries at or beyond the count are never read. The
// effective limit is the smaller of the capacity register and CAPACITY.
module sorted_table_engine import ste_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [VALUE_W-1:0] in_value_in,
  input  logic [INDEX_W-1:0] in_index_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [VALUE_W-1:0] out_value_out,
  output logic [INDEX_W-1:0] out_index_out,
  output logic [COUNT_W-1:0] out_count_out,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [COUNT_W-1:0] cap_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [VALUE_W-1:0] value_r;
  logic [INDEX_W-1:0] index_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               accept;
  logic               fire;
  logic               full;
  logic               idx_ok;
  ste_ctrl_t          ctrl;

  logic [VALUE_W-1:0] values [CAPACITY];
  logic [VALUE_W-1:0] prev_values [CAPACITY];
  logic [VALUE_W-1:0] next_values [CAPACITY];
  logic [CAPACITY-1:0] le_w, eq_w, prev_le_w, prev_eq_w;
  logic [CAPACITY-1:0] ins_mark_w, find_mark_w, hit_w;

  logic [IW-1:0]      ins_pos, find_pos;
  logic               found;
  logic [VALUE_W-1:0] get_value;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign full   = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= 32'(CAPACITY));
  assign idx_ok = 32'(index_r) < 32'(count_r);

  always_comb begin
    ctrl.ins     = fire && (cmd_r == CMD_INSERT) && !full;
    ctrl.del_idx = fire && (cmd_r == CMD_DELETE) && idx_ok;
    ctrl.del_val = fire && (cmd_r == CMD_DELETE_VALUE) && found;
    ctrl.value   = value_r;
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign prev_values[g] = '0;
        assign prev_le_w[g]   = 1'b1;
        assign prev_eq_w[g]   = 1'b0;
      end else begin : g_mid
        assign prev_values[g] = values[g-1];
        assign prev_le_w[g]   = le_w[g-1];
        assign prev_eq_w[g]   = eq_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_values[g] = '0;
      end else begin : g_body
        assign next_values[g] = values[g+1];
      end

      ste_cell #(
        .IDX (g),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .load       (accept),
        .cmp_value  (in_value_in),
        .cmp_index  (in_index_in),
        .count      (count_r),
        .ctrl       (ctrl),
        .prev_value (prev_values[g]),
        .prev_le    (prev_le_w[g]),
        .prev_eq    (prev_eq_w[g]),
        .next_value (next_values[g]),
        .value      (values[g]),
        .le         (le_w[g]),
        .eq         (eq_w[g]),
        .ins_mark   (ins_mark_w[g]),
        .find_mark  (find_mark_w[g]),
        .hit        (hit_w[g])
      );
    end
  endgenerate

  ste_encode #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_encode (
    .ins_mark  (ins_mark_w),
    .find_mark (find_mark_w),
    .hit       (hit_w),
    .values    (values),
    .ins_pos   (ins_pos),
    .find_pos  (find_pos),
    .found     (found),
    .get_value (get_value)
  );

  always_comb begin
    logic [31:0] ins_pos32;
    logic [31:0] find_pos32;
    logic [31:0] count32;
    ins_pos32     = 32'(ins_pos);
    find_pos32    = 32'(find_pos);
    count32       = '0;
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_count_nxt = out_count_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_value_nxt = '0;
          out_index_nxt = '0;
          case (cmd_r)
            CMD_INSERT: begin
              if (!full) begin
                out_ok_nxt    = 1'b1;
                out_index_nxt = ins_pos32[INDEX_W-1:0];
                count_nxt     = CW'(count_r + CW'(1));
              end
            end
            CMD_GET: begin
              if (idx_ok) begin
                out_ok_nxt    = 1'b1;
                out_value_nxt = get_value;
                out_index_nxt = index_r;
              end
            end
            CMD_FIND: begin
              if (found) begin
                out_ok_nxt    = 1'b1;
                out_index_nxt = find_pos32[INDEX_W-1:0];
              end
            end
            CMD_DELETE: begin
              if (idx_ok) begin
                out_ok_nxt    = 1'b1;
                out_index_nxt = index_r;
                count_nxt     = CW'(count_r - CW'(1));
              end
            end
            CMD_DELETE_VALUE: begin
              if (found) begin
                out_ok_nxt    = 1'b1;
                out_index_nxt = find_pos32[INDEX_W-1:0];
                count_nxt     = CW'(count_r - CW'(1));
              end
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
          count32       = 32'(count_nxt);
          out_count_nxt = count32[COUNT_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      value_r <= in_value_in;
      index_r <= in_index_in;
    end
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_value_r;
  assign out_index_out = out_index_r;
  assign out_count_out = out_count_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted word did not start execution");

  a_count_at_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("count changed outside command completion");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("completed command left no result");
`endif

endmodule

// ===== dv/sorted_table_engine_test.sv =====
// self-checking testbench for the sorted table engine with a queue-based table predictor
module sorted_table_engine_test;
  import ste_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int unsigned      SETTLE_CYCLES    = 6;
  localparam int unsigned      WATCHDOG_LIMIT   = 2000;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } table_reply_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd;
  logic [VALUE_W-1:0] in_value_in;
  logic [INDEX_W-1:0] in_index_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [VALUE_W-1:0] out_value_out;
  logic [INDEX_W-1:0] out_index_out;
  logic [COUNT_W-1:0] out_count_out;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  logic [VALUE_W-1:0] sorted_words[$];
  logic [COUNT_W-1:0] capacity_reg;
  table_reply_t       pending_replies[$];
  int unsigned        fault_count = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        stall_left = 0;
  logic               idle_on = 1'b1;

  sorted_table_engine uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value_in  (in_value_in),
    .in_index_in  (in_index_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_value_out(out_value_out),
    .out_index_out(out_index_out),
    .out_count_out(out_count_out),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int first_position(input logic [VALUE_W-1:0] value);
    for (int p = 0; p < sorted_words.size(); p++) begin
      if (sorted_words[p] == value) return p;
    end
    return -1;
  endfunction

  function automatic table_reply_t apply_to_table(input logic [CMD_W-1:0] cmd,
                                                  input logic [VALUE_W-1:0] value,
                                                  input logic [INDEX_W-1:0] index);
    table_reply_t reply;
    int           pos;
    int           word_limit;
    reply = '0;
    word_limit = (capacity_reg < DEF_CAPACITY) ? int'(capacity_reg) : int'(DEF_CAPACITY);
    case (cmd)
      CMD_INSERT: begin
        if (sorted_words.size() < word_limit) begin
          pos = 0;
          while (pos < sorted_words.size() && sorted_words[pos] <= value) pos++;
          sorted_words.insert(pos, value);
          reply.ok = 1'b1;
          reply.index = INDEX_W'(pos);
        end
      end
      CMD_GET: begin
        if (index < sorted_words.size()) begin
          reply.ok = 1'b1;
          reply.value = sorted_words[index];
          reply.index = index;
        end
      end
      CMD_FIND: begin
        pos = first_position(value);
        if (pos >= 0) begin
          reply.ok = 1'b1;
          reply.index = INDEX_W'(pos);
        end
      end
      CMD_DELETE: begin
        if (index < sorted_words.size()) begin
          sorted_words.delete(index);
          reply.ok = 1'b1;
          reply.index = index;
        end
      end
      CMD_DELETE_VALUE: begin
        pos = first_position(value);
        if (pos >= 0) begin
          sorted_words.delete(pos);
          reply.ok = 1'b1;
          reply.index = INDEX_W'(pos);
        end
      end
      default: ;
    endcase
    reply.count = COUNT_W'(sorted_words.size());
    return reply;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5 && sorted_words.size() != 0)
      return sorted_words[$urandom_range(0, sorted_words.size() - 1)];
    if (roll < 8) return VALUE_W'($urandom_range(0, 15));
    if (roll == 8) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (sorted_words.size() != 0 && $urandom_range(0, 3) != 0)
      return INDEX_W'($urandom_range(0, sorted_words.size() - 1));
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_value_in <= value;
    in_index_in <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(apply_to_table(cmd, value, index));
  endtask

  task automatic settle_table();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] cap);
    settle_table();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic test_basic_commands();
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 8'd0);
    send_word(CMD_INSERT, 32'h0000_0000, 8'hFF);
    send_word(CMD_INSERT, 32'd5, 8'd0);
    send_word(CMD_INSERT, 32'd5, 8'd0);
    send_word(CMD_INSERT, 32'd3, 8'd0);
    send_word(CMD_INSERT, 32'h8000_0000, 8'd0);
    send_word(CMD_GET, 32'hFFFF_FFFF, 8'd0);
    send_word(CMD_GET, 32'd0, 8'd5);
    send_word(CMD_GET, 32'd0, 8'd6);
    send_word(CMD_GET, 32'd0, 8'hFF);
    send_word(CMD_FIND, 32'd5, 8'hFF);
    send_word(CMD_FIND, 32'd4, 8'd0);
    send_word(CMD_FIND, 32'hFFFF_FFFF, 8'd0);
    send_word(CMD_DELETE_VALUE, 32'd5, 8'd0);
    send_word(CMD_DELETE_VALUE, 32'd7, 8'd0);
    send_word(CMD_DELETE, 32'd0, 8'd0);
    send_word(CMD_DELETE, 32'd0, 8'd200);
    send_word(CMD_DELETE, 32'd0, INDEX_W'(sorted_words.size() - 1));
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_word(CMD_W'(c), $urandom, INDEX_W'($urandom_range(0, 255)));
  endtask

  task automatic test_capacity_limits();
    while (sorted_words.size() != 0) send_word(CMD_DELETE, $urandom, 8'd0);
    write_capacity(9'd0);
    send_word(CMD_INSERT, 32'd9, 8'd0);
    send_word(CMD_GET, 32'd0, 8'd0);
    send_word(CMD_DELETE, 32'd0, 8'd0);
    send_word(CMD_FIND, 32'd9, 8'd0);
    send_word(CMD_DELETE_VALUE, 32'd9, 8'd0);
    write_capacity(9'd3);
    repeat (4) send_word(CMD_INSERT, pick_value(), pick_index());
    write_capacity(9'd1);
    send_word(CMD_INSERT, 32'd1, 8'd0);
    send_word(CMD_DELETE, 32'd0, 8'd1);
    write_capacity(9'h1FF);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 8'd0);
  endtask

  task automatic test_random_mix(input logic [COUNT_W-1:0] cap, input int unsigned op_total);
    logic [CMD_W-1:0] cmd;
    int unsigned      roll;
    write_capacity(cap);
    for (int n = 0; n < op_total; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) cmd = CMD_INSERT;
      else if (roll < 55) cmd = CMD_GET;
      else if (roll < 68) cmd = CMD_FIND;
      else if (roll < 81) cmd = CMD_DELETE;
      else if (roll < 95) cmd = CMD_DELETE_VALUE;
      else cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      send_word(cmd, pick_value(), pick_index());
    end
  endtask

  task automatic test_full_table();
    write_capacity(CAP_RESET);
    while (sorted_words.size() < DEF_CAPACITY)
      send_word(CMD_INSERT, pick_value(), pick_index());
    send_word(CMD_INSERT, 32'd0, 8'd0);
    send_word(CMD_GET, 32'd0, 8'hFF);
    send_word(CMD_FIND, sorted_words[DEF_CAPACITY - 1], 8'd0);
    send_word(CMD_DELETE, 32'd0, 8'hFF);
    send_word(CMD_GET, 32'd0, 8'hFF);
    send_word(CMD_DELETE_VALUE, sorted_words[0], 8'd0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 8'd0);
    send_word(CMD_INSERT, 32'd0, 8'd0);
    send_word(CMD_INSERT, 32'd1, 8'd0);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : reply_checker
    table_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected word ok=%0b value=%h index=%0d count=%0d", $time,
                   out_ok, out_value_out, out_index_out, out_count_out);
      end else begin
        want = pending_replies.pop_front();
        if (out_ok !== want.ok || out_value_out !== want.value ||
            out_index_out !== want.index || out_count_out !== want.count) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: mismatch exp %0b %h %0d %0d, got %0b %h %0d %0d",
                     $time, want.ok, want.value, want.index, want.count,
                     out_ok, out_value_out, out_index_out, out_count_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= CMD_INSERT;
    in_value_in <= '0;
    in_index_in <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    capacity_reg = CAP_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_commands();
    test_capacity_limits();
    test_random_mix(9'd12, 25);
    test_random_mix(9'd1, 25);
    test_random_mix(9'd40, 25);
    test_random_mix(9'h1FF, 25);
    idle_on = 1'b0;
    test_full_table();
    settle_table();
    if (fault_count == 0 && pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
